FILE: sv/bmp_row_pixel_unpacker_top_defines.svh
// Assertion macros for the bitmap row pixel unpacker.
`ifndef BMP_ROW_PIXEL_UNPACKER_TOP_DEFINES_SVH
`define BMP_ROW_PIXEL_UNPACKER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BMPUNP_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bmpunp assertion failed");
`define BMPUNP_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bmpunp assertion failed");
`else
`define BMPUNP_ASSERT_IMP(label, pre, post)
`define BMPUNP_ASSERT_NXT(label, pre, post)
`endif
`endif

FILE: sv/bmpunp_pkg.sv
// Shared types and constants of the bitmap row pixel unpacker.
`default_nettype none
package bmpunp_pkg;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_ROW_PIXELS = 65535;
  localparam int CODE_W = 32;
  localparam int BUF_W = 39;
  localparam int CNT_W = 6;
  localparam int COL_W = 16;
  localparam int RBC_W = 18;
  localparam int CH_W = 8;
  localparam int IDX_W = 3;
  localparam int CFG_W = 32;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_BPP      = 3'd0,
    REG_ROW_PIX  = 3'd1,
    REG_PAL_CNT  = 3'd2,
    REG_ROT      = 3'd3,
    REG_MASK_B   = 3'd4,
    REG_MASK_G   = 3'd5,
    REG_MASK_R   = 3'd6,
    REG_MASK_A   = 3'd7
  } cfg_reg_t;

  // Palette writes carry {index, red, green, blue} in the code field.
  typedef struct packed {
    logic              pal_write;
    logic [CODE_W-1:0] code;
    logic              row_end;
    logic              last;
  } mid_item_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
    logic            row_end;
    logic            oor;
    logic            last;
  } pix_t;

  typedef struct packed {
    logic [CNT_W-1:0]  depth;
    logic [8:0]        pal_count;
    logic [4:0]        rot;
    logic [CODE_W-1:0] mask_b;
    logic [CODE_W-1:0] mask_g;
    logic [CODE_W-1:0] mask_r;
    logic [CODE_W-1:0] mask_a;
  } back_cfg_t;
endpackage
`default_nettype wire

FILE: sv/bmp_row_pixel_unpacker_top.sv
// Top level of the bitmap row pixel unpacker: registers, front, queues, back.
//
//  channel  | handshake              | payload
//  input    | push / full            | op, data_byte, palette_index, palette_blue/green/red
//  result   | pop / empty            | blue, green, red, alpha, row_end, index_out_of_range, last
//  config   | cfg_write              | cfg_index, cfg_data
//
// A data byte holds the front until every pixel it yields has entered the queue.
// A palette pixel passes the back end through a palette RAM read (state B_PAL);
// a bitfield pixel goes through the eight-step per-channel divider (B_DIV, then B_OUT).
// Reset is synchronous; a register write restarts the current row.
// Either side stalls on its own through a four-entry queue and a two-entry output FIFO.
`include "bmp_row_pixel_unpacker_top_defines.svh"
`default_nettype none
module bmp_row_pixel_unpacker_top import bmpunp_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             op,
  input  wire logic [7:0]       data_byte,
  input  wire logic [7:0]       palette_index,
  input  wire logic [7:0]       palette_blue,
  input  wire logic [7:0]       palette_green,
  input  wire logic [7:0]       palette_red,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            blue,
  output logic [7:0]            green,
  output logic [7:0]            red,
  output logic [7:0]            alpha,
  output logic                  row_end,
  output logic                  index_out_of_range,
  output logic                  last
);
  logic [5:0]        bits_per_pixel;
  logic [15:0]       row_pixels;
  logic [8:0]        palette_count;
  logic [4:0]        rotation_left;
  logic [31:0]       mask_blue;
  logic [31:0]       mask_green;
  logic [31:0]       mask_red;
  logic [31:0]       mask_alpha;

  logic [CNT_W-1:0]  depth;
  logic [COL_W-1:0]  width;
  logic [21:0]       bits_row;
  logic [21:0]       bits_up;
  logic [RBC_W-1:0]  stride;
  back_cfg_t         bcfg;

  logic              mid_push;
  mid_item_t         mid_wr;
  logic              mid_full;
  logic              mid_pop;
  mid_item_t         mid_rd;
  logic              mid_empty;
  logic              o_push;
  pix_t              o_item;
  logic              o_full;
  pix_t              o_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= 6'd8;
      row_pixels     <= 16'd1;
      palette_count  <= 9'd256;
      rotation_left  <= '0;
      mask_blue      <= '0;
      mask_green     <= '0;
      mask_red       <= '0;
      mask_alpha     <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BPP:     bits_per_pixel <= cfg_data[5:0];
        REG_ROW_PIX: row_pixels     <= cfg_data[15:0];
        REG_PAL_CNT: palette_count  <= cfg_data[8:0];
        REG_ROT:     rotation_left  <= cfg_data[4:0];
        REG_MASK_B:  mask_blue      <= cfg_data;
        REG_MASK_G:  mask_green     <= cfg_data;
        REG_MASK_R:  mask_red       <= cfg_data;
        REG_MASK_A:  mask_alpha     <= cfg_data;
        default:     mask_alpha     <= mask_alpha;
      endcase
    end
  end

  assign depth    = (bits_per_pixel == '0) ? CNT_W'(1)
                  : (bits_per_pixel > CNT_W'(32)) ? CNT_W'(32) : bits_per_pixel;
  assign width    = (row_pixels == '0) ? COL_W'(1)
                  : (32'(row_pixels) > 32'(MAX_ROW_PIXELS)) ? COL_W'(MAX_ROW_PIXELS)
                  : row_pixels;
  assign bits_row = 22'(depth) * 22'(width);
  assign bits_up  = bits_row + 22'd31;
  assign stride   = RBC_W'({bits_up[21:5], 2'b00});

  assign bcfg.depth     = depth;
  assign bcfg.pal_count = palette_count;
  assign bcfg.rot       = rotation_left;
  assign bcfg.mask_b    = mask_blue;
  assign bcfg.mask_g    = mask_green;
  assign bcfg.mask_r    = mask_red;
  assign bcfg.mask_a    = mask_alpha;

  bmpunp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_write),
    .depth         (depth),
    .width         (width),
    .stride        (stride),
    .push          (push),
    .op            (op),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_blue  (palette_blue),
    .palette_green (palette_green),
    .palette_red   (palette_red),
    .full          (full),
    .q_push        (mid_push),
    .q_item        (mid_wr),
    .q_full        (mid_full)
  );

  bmpunp_fifo #(.W($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  bmpunp_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (bcfg),
    .q_empty (mid_empty),
    .q_pop   (mid_pop),
    .q_item  (mid_rd),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_item  (o_item)
  );

  bmpunp_fifo #(.W($bits(pix_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (o_push),
    .wr_data (o_item),
    .full    (o_full),
    .pop     (pop),
    .rd_data (o_head),
    .empty   (empty)
  );

  assign blue               = o_head.blue;
  assign green              = o_head.green;
  assign red                = o_head.red;
  assign alpha              = o_head.alpha;
  assign row_end            = o_head.row_end;
  assign index_out_of_range = o_head.oor;
  assign last               = o_head.last;

  `BMPUNP_ASSERT_IMP(a_out_no_overflow, o_push, !o_full)
  `BMPUNP_ASSERT_IMP(a_mid_pop_nonempty, mid_pop, !mid_empty)
  `BMPUNP_ASSERT_NXT(a_cfg_restarts_front, cfg_write, full == mid_full)
  `BMPUNP_ASSERT_IMP(a_oor_blank, !empty && index_out_of_range, alpha == 8'h00)
endmodule
`default_nettype wire

FILE: sv/bmpunp_fifo.sv
// Small register FIFO used between the stages and at the output.
`default_nettype none
module bmpunp_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/bmpunp_front.sv
// Front end: takes input transactions, slices pixel codes out of the byte stream.
`default_nettype none
module bmpunp_front import bmpunp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic [CNT_W-1:0] depth,
  input  wire logic [COL_W-1:0] width,
  input  wire logic [RBC_W-1:0] stride,
  input  wire logic             push,
  input  wire logic             op,
  input  wire logic [7:0]       data_byte,
  input  wire logic [7:0]       palette_index,
  input  wire logic [7:0]       palette_blue,
  input  wire logic [7:0]       palette_green,
  input  wire logic [7:0]       palette_red,
  output logic                  full,
  output logic                  q_push,
  output mid_item_t             q_item,
  input  wire logic             q_full
);
  typedef enum logic {F_IDLE, F_EMIT} fstate_t;

  fstate_t          state;
  logic [BUF_W-1:0] bitbuf;
  logic [CNT_W-1:0] bitcnt;
  logic [COL_W-1:0] column;
  logic [RBC_W-1:0] rbc;
  logic             restart_pending;

  logic             accept;
  logic [RBC_W-1:0] rbc_inc;
  logic             stride_hit;
  logic             can_emit;
  logic [CNT_W-1:0] cnt_left;
  logic [COL_W-1:0] col_inc;
  logic [BUF_W-1:0] shifted;
  logic [CODE_W:0]  dmask;
  logic [CODE_W-1:0] code;

  assign full       = (state != F_IDLE) || q_full;
  assign accept     = push && !full;
  assign rbc_inc    = rbc + 1'b1;
  assign stride_hit = (rbc_inc >= stride);
  assign can_emit   = (bitcnt >= depth) && (column < width);
  assign cnt_left   = bitcnt - depth;
  assign col_inc    = column + 1'b1;
  assign shifted    = bitbuf >> cnt_left;
  assign dmask      = ({{CODE_W{1'b0}}, 1'b1} << depth) - 1'b1;
  assign code       = shifted[CODE_W-1:0] & dmask[CODE_W-1:0];

  always_comb begin
    q_push = 1'b0;
    q_item = '0;
    if (state == F_IDLE) begin
      q_push = accept && op;
      q_item.pal_write = 1'b1;
      q_item.code = {palette_index, palette_red, palette_green, palette_blue};
    end else begin
      q_push = can_emit;
      q_item.code = code;
      q_item.row_end = (col_inc == width);
      q_item.last = (cnt_left < depth) || (col_inc == width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state           <= F_IDLE;
      bitbuf          <= '0;
      bitcnt          <= '0;
      column          <= '0;
      rbc             <= '0;
      restart_pending <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && !op) begin
            if (column < width) begin
              bitbuf          <= {bitbuf[BUF_W-9:0], data_byte};
              bitcnt          <= bitcnt + CNT_W'(8);
              rbc             <= rbc_inc;
              restart_pending <= stride_hit;
              state           <= F_EMIT;
            end else if (stride_hit) begin
              bitbuf <= '0;
              bitcnt <= '0;
              column <= '0;
              rbc    <= '0;
            end else begin
              rbc <= rbc_inc;
            end
          end
        end
        F_EMIT: begin
          if (can_emit) begin
            // advance only when the queue takes the code
            if (!q_full) begin
              bitcnt <= cnt_left;
              column <= col_inc;
            end
          end else begin
            if (restart_pending) begin
              bitbuf <= '0;
              bitcnt <= '0;
              column <= '0;
              rbc    <= '0;
            end
            restart_pending <= 1'b0;
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/bmpunp_back.sv
// Back end: palette lookup or mask scaling, one pixel at a time.
`default_nettype none
module bmpunp_back import bmpunp_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  back_cfg_t      cfg,
  input  wire logic      q_empty,
  output logic           q_pop,
  input  mid_item_t      q_item,
  input  wire logic      o_full,
  output logic           o_push,
  output pix_t           o_item
);
  localparam int AW = $clog2(PALETTE_ENTRIES);

  typedef enum logic [1:0] {B_IDLE, B_PAL, B_DIV, B_OUT} bstate_t;

  logic [23:0]       pal_mem [PALETTE_ENTRIES];
  logic [23:0]       pal_q;
  bstate_t           state;
  logic              row_end;
  logic              last;
  logic              oor;
  logic [2:0]        step;
  logic [CODE_W:0]   rem  [4];
  logic [7:0]        low  [4];
  logic [7:0]        quo  [4];

  logic [CODE_W-1:0] masks [4];
  logic [8:0]        limit;
  logic              pal_mode;
  logic [CNT_W-1:0]  r0, r1, r2, rot;
  logic [2*CODE_W-1:0] wide;
  logic [2*CODE_W-1:0] wrap;
  logic [CODE_W:0]   dmask;
  logic [CODE_W-1:0] rcode;
  logic [7:0]        idx;
  logic              start;

  assign masks[0] = cfg.mask_b;
  assign masks[1] = cfg.mask_g;
  assign masks[2] = cfg.mask_r;
  assign masks[3] = cfg.mask_a;
  assign limit    = (cfg.pal_count < 9'(PALETTE_ENTRIES)) ? cfg.pal_count
                                                           : 9'(PALETTE_ENTRIES);
  assign pal_mode = (cfg.depth <= CNT_W'(8));

  // rotation modulo depth; depth is at least nine here, so three subtracts do
  always_comb begin
    r0  = {1'b0, cfg.rot};
    r1  = (r0 >= cfg.depth) ? r0 - cfg.depth : r0;
    r2  = (r1 >= cfg.depth) ? r1 - cfg.depth : r1;
    rot = (r2 >= cfg.depth) ? r2 - cfg.depth : r2;
  end

  assign dmask = ({{CODE_W{1'b0}}, 1'b1} << cfg.depth) - 1'b1;
  assign wide  = {{CODE_W{1'b0}}, q_item.code} << rot;
  assign wrap  = wide >> cfg.depth;
  assign rcode = (wide[CODE_W-1:0] | wrap[CODE_W-1:0]) & dmask[CODE_W-1:0];
  assign idx   = q_item.code[31:24];

  assign start = (state == B_IDLE) && !q_empty && !o_full;
  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (start && q_item.pal_write && (9'(idx) < 9'(PALETTE_ENTRIES))) begin
      pal_mem[idx[AW-1:0]] <= q_item.code[23:0];
    end
    pal_q <= pal_mem[q_item.code[AW-1:0]];
  end

  always_comb begin
    o_push = 1'b0;
    o_item = '0;
    o_item.row_end = row_end;
    o_item.last    = last;
    if (state == B_PAL) begin
      o_push = 1'b1;
      o_item.oor = oor;
      if (!oor) begin
        o_item.blue  = pal_q[7:0];
        o_item.green = pal_q[15:8];
        o_item.red   = pal_q[23:16];
        o_item.alpha = 8'hFF;
      end
    end else if (state == B_OUT) begin
      o_push = 1'b1;
      o_item.blue  = (masks[0] == '0) ? 8'h00 : quo[0];
      o_item.green = (masks[1] == '0) ? 8'h00 : quo[1];
      o_item.red   = (masks[2] == '0) ? 8'h00 : quo[2];
      o_item.alpha = (masks[3] == '0) ? 8'hFF : quo[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (start && !q_item.pal_write) begin
            row_end <= q_item.row_end;
            last    <= q_item.last;
            oor     <= (q_item.code >= CODE_W'(limit));
            if (pal_mode) begin
              state <= B_PAL;
            end else begin
              // x*255 split as a quotient-sized head and eight low bits
              for (int i = 0; i < 4; i++) begin
                logic [CODE_W+7:0] d;
                d = {rcode & masks[i], 8'h00} - {8'h00, rcode & masks[i]};
                rem[i] <= {1'b0, d[CODE_W+7:8]};
                low[i] <= d[7:0];
                quo[i] <= '0;
              end
              step  <= '0;
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          for (int i = 0; i < 4; i++) begin
            logic [CODE_W:0] t;
            logic            ge;
            t  = {rem[i][CODE_W-1:0], low[i][7]};
            ge = (t >= {1'b0, masks[i]});
            rem[i] <= ge ? t - {1'b0, masks[i]} : t;
            low[i] <= {low[i][6:0], 1'b0};
            quo[i] <= {quo[i][6:0], ge};
          end
          step <= step + 1'b1;
          if (step == 3'd7) begin
            state <= B_OUT;
          end
        end
        B_PAL:   state <= B_IDLE;
        B_OUT:   state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
